>>> hw/rtl/ts_pes_pkg.sv
package ts_pes_pkg;

    localparam int PAYLOAD_W = 8;
    localparam int PID_W     = 13;
    localparam int CC_W      = 4;
    localparam int SIZE_W    = 24;
    localparam int HLEN_W    = 9;
    localparam int PLEN_W    = 16;
    localparam int SID_W     = 8;

    localparam logic [SIZE_W-1:0] SIZE_MAX = {SIZE_W{1'b1}};

    // Stream ids whose PES header carries no optional part
    localparam logic [SID_W-1:0] SID_PROGRAM_MAP  = 8'hBC;
    localparam logic [SID_W-1:0] SID_PADDING      = 8'hBE;
    localparam logic [SID_W-1:0] SID_PRIVATE_2    = 8'hBF;
    localparam logic [SID_W-1:0] SID_ECM          = 8'hF0;
    localparam logic [SID_W-1:0] SID_EMM          = 8'hF1;
    localparam logic [SID_W-1:0] SID_DSMCC        = 8'hF2;
    localparam logic [SID_W-1:0] SID_H222_E       = 8'hF8;
    localparam logic [SID_W-1:0] SID_DIRECTORY    = 8'hFF;

    localparam logic [HLEN_W-1:0] HLEN_SHORT = 9'd6;
    localparam logic [HLEN_W-1:0] HLEN_LONG  = 9'd9;

    typedef enum logic [2:0] {
        ST_WRONG_PID    = 3'd0,
        ST_STARTED      = 3'd1,
        ST_CONTINUE     = 3'd2,
        ST_FINISHED     = 3'd3,
        ST_LOST         = 3'd4,
        ST_NOT_STARTED  = 3'd5
    } t_status;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_STATUS  = 1'b1
    } t_kind;

    typedef struct packed {
        logic                  last;
        t_kind                 kind;
        logic [SID_W-1:0]      stream_id;
        logic [PLEN_W-1:0]     pes_packet_length;
        logic [HLEN_W-1:0]     pes_header_length;
        logic [SIZE_W-1:0]     assembled_size;
        logic [CC_W-1:0]       continuity;
        logic [PID_W-1:0]      packet_pid;
        t_status               status;
        logic [PAYLOAD_W-1:0]  payload_byte;
    } t_result;

    localparam int TDATA_BITS = PAYLOAD_W + 3 + PID_W + CC_W + SIZE_W + HLEN_W + PLEN_W + SID_W;
    localparam int TDATA_W    = ((TDATA_BITS + 7) / 8) * 8;

    function automatic logic [HLEN_W-1:0] pes_hdr_len(input logic [SID_W-1:0] sid,
                                                      input logic [7:0] extra);
        logic [HLEN_W-1:0] len;
        case (sid) inside
            SID_PROGRAM_MAP, SID_PADDING, SID_PRIVATE_2, SID_ECM, SID_EMM,
            SID_DSMCC, SID_H222_E, SID_DIRECTORY: len = HLEN_SHORT;
            default: len = HLEN_LONG + {1'b0, extra};
        endcase
        return len;
    endfunction

endpackage

>>> hw/rtl/ts_pes_assembler_core.sv
// Channel   | Direction | Lines                  | Contents
// s_axis    | in        | tdata[7:0], tuser      | stream byte; tuser = packet start flag
// m_axis    | out       | tdata[87:0], tuser, tlast | result fields; tuser = kind, tlast = last
// cfg       | in        | i_cfg_we, i_cfg_wdata  | target PID
//
// One stream byte is taken per cycle while s_axis_tready is high; its results
// enter a 4-entry output queue in the same edge and leave at most one per
// cycle, first in the cycle after. The last byte of a packet may produce two
// results, so s_axis_tready drops while fewer than two queue entries are free.
// Reset (synchronous, active low) clears parser state, queue and target PID to 8191.
module ts_pes_assembler_core
    import ts_pes_pkg::*;
#(
    parameter int PACKET_BYTES = 188
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [PID_W-1:0]     i_cfg_wdata,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [7:0] stream_byte
    input  logic                 s_axis_tuser,   // [0] packet_start
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [7:0] payload_byte, [10:8] status, [23:11] packet_pid, [27:24] continuity,
    // [51:28] assembled_size, [60:52] pes_header_length, [76:61] pes_packet_length,
    // [84:77] stream_id, [87:85] zero
    output logic [TDATA_W-1:0]   m_axis_tdata,
    output logic                 m_axis_tuser,   // [0] kind
    output logic                 m_axis_tlast
);

    localparam int PW    = $clog2(PACKET_BYTES + 1);
    localparam int CW    = ((PW > 8) ? PW : 8) + 1;
    localparam int DEPTH = 4;
    localparam int AW    = 2;

    // parser state
    logic [PID_W-1:0]  r_target_pid;
    logic [PW-1:0]     r_byte_pos,   n_byte_pos;
    logic [31:0]       r_hdr_word,   n_hdr_word;
    logic [7:0]        r_adapt_len,  n_adapt_len;
    logic              r_assembling, n_assembling;
    logic [CC_W-1:0]   r_last_cc,    n_last_cc;
    logic              r_pkt_acc,    n_pkt_acc;
    t_status           r_pkt_status, n_pkt_status;
    t_status           w_pay_status;
    logic [SIZE_W-1:0] r_gathered,   n_gathered;
    logic [3:0]        r_pes_idx,    n_pes_idx;
    logic [SID_W-1:0]  r_pes_sid,    n_pes_sid;
    logic [PLEN_W-1:0] r_pes_len,    n_pes_len;
    logic [7:0]        r_pes_extra,  n_pes_extra;

    logic              w_in_acc;
    logic [PW-1:0]     w_p;
    logic              w_in_range;
    logic              w_payload;
    logic              w_push_pay;
    logic              w_push_status;
    logic [PID_W-1:0]  w_pid;
    logic [CC_W-1:0]   w_cc;
    logic [HLEN_W-1:0] w_hlen;
    t_result           w_res_pay;
    t_result           w_res_status;

    // output queue
    t_result           r_mem [DEPTH];
    logic [AW-1:0]     r_wr_ptr;
    logic [AW-1:0]     r_rd_ptr;
    logic [AW:0]       r_count;
    logic              w_pop;
    logic [1:0]        w_npush;
    t_result           w_head;

    assign w_in_acc   = s_axis_tvalid && s_axis_tready;
    assign w_p        = s_axis_tuser ? '0 : r_byte_pos;
    assign w_in_range = (w_p < PW'(PACKET_BYTES));

    always_comb begin
        n_byte_pos   = r_byte_pos;
        n_hdr_word   = r_hdr_word;
        n_adapt_len  = r_adapt_len;
        n_assembling = r_assembling;
        n_last_cc    = r_last_cc;
        n_pkt_acc    = r_pkt_acc;
        n_pkt_status = r_pkt_status;
        n_gathered   = r_gathered;
        n_pes_idx    = r_pes_idx;
        n_pes_sid    = r_pes_sid;
        n_pes_len    = r_pes_len;
        n_pes_extra  = r_pes_extra;
        w_payload    = 1'b0;
        w_pid        = '0;
        w_cc         = '0;

        if (w_in_acc && w_in_range) begin
            n_byte_pos = w_p + 1'b1;
            if (w_p == '0) begin
                n_hdr_word   = {24'd0, s_axis_tdata};
                n_pkt_acc    = 1'b0;
                n_pkt_status = ST_WRONG_PID;
            end else if (w_p <= PW'(3)) begin
                n_hdr_word = {r_hdr_word[23:0], s_axis_tdata};
                if (w_p == PW'(3)) begin
                    w_pid     = n_hdr_word[20:8];
                    w_cc      = n_hdr_word[3:0];
                    n_pkt_acc = 1'b0;
                    if (w_pid != r_target_pid) begin
                        n_pkt_status = ST_WRONG_PID;
                    end else if (n_hdr_word[22]) begin
                        n_gathered   = '0;
                        n_pes_idx    = '0;
                        n_pes_sid    = '0;
                        n_pes_len    = '0;
                        n_pes_extra  = '0;
                        n_assembling = 1'b1;
                        n_last_cc    = w_cc;
                        n_pkt_acc    = 1'b1;
                        n_pkt_status = ST_STARTED;
                    end else if (!r_assembling) begin
                        n_pkt_status = ST_NOT_STARTED;
                    end else if (r_last_cc + 1'b1 != w_cc) begin
                        n_assembling = 1'b0;
                        n_gathered   = '0;
                        n_pkt_status = ST_LOST;
                    end else begin
                        n_last_cc    = w_cc;
                        n_pkt_acc    = 1'b1;
                        n_pkt_status = ST_CONTINUE;
                    end
                end
            end else if (r_hdr_word[5]) begin
                if (w_p == PW'(4)) begin
                    n_adapt_len = s_axis_tdata;
                end else if (CW'(w_p) >= CW'(5) + CW'(r_adapt_len)) begin
                    w_payload = 1'b1;
                end
            end else begin
                w_payload = 1'b1;
            end

            if (w_payload && r_pkt_acc) begin
                // capture PES header fields from the start packet only
                if (r_pkt_status == ST_STARTED && r_pes_idx < 4'd9) begin
                    case (r_pes_idx)
                        4'd3:    n_pes_sid = s_axis_tdata;
                        4'd4:    n_pes_len = {s_axis_tdata, r_pes_len[7:0]};
                        4'd5:    n_pes_len = {r_pes_len[15:8], s_axis_tdata};
                        4'd8:    n_pes_extra = s_axis_tdata;
                        default: ;
                    endcase
                    n_pes_idx = r_pes_idx + 1'b1;
                end
                if (r_gathered != SIZE_MAX) begin
                    n_gathered = r_gathered + 1'b1;
                end
            end

            if (w_p == PW'(PACKET_BYTES - 1)) begin
                if (r_pkt_acc && r_pkt_status == ST_CONTINUE && n_pes_len != '0 &&
                    n_gathered >= SIZE_W'({1'b0, n_pes_len} + 17'd6)) begin
                    n_pkt_status = ST_FINISHED;
                    n_assembling = 1'b0;
                end
            end
        end
    end

    assign w_push_pay    = w_in_acc && w_in_range && w_payload && r_pkt_acc;
    assign w_push_status = w_in_acc && w_in_range && (w_p == PW'(PACKET_BYTES - 1));
    assign w_hlen        = pes_hdr_len(n_pes_sid, n_pes_extra);
    // payload result shows the status before the finish check
    assign w_pay_status  = r_pkt_status;

    always_comb begin
        w_res_pay.last              = !w_push_status;
        w_res_pay.kind              = KIND_PAYLOAD;
        w_res_pay.stream_id         = n_pes_sid;
        w_res_pay.pes_packet_length = n_pes_len;
        w_res_pay.pes_header_length = w_hlen;
        w_res_pay.assembled_size    = n_gathered;
        w_res_pay.continuity        = n_hdr_word[3:0];
        w_res_pay.packet_pid        = n_hdr_word[20:8];
        w_res_pay.status            = w_pay_status;
        w_res_pay.payload_byte      = s_axis_tdata;

        w_res_status                = w_res_pay;
        w_res_status.last           = 1'b1;
        w_res_status.kind           = KIND_STATUS;
        w_res_status.status         = n_pkt_status;
        w_res_status.payload_byte   = '0;
    end

    assign w_npush       = {1'b0, w_push_pay} + {1'b0, w_push_status};
    assign w_pop         = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = (r_count <= (AW+1)'(DEPTH - 2));
    assign w_head        = r_mem[r_rd_ptr];

    assign m_axis_tvalid = (r_count != '0);
    assign m_axis_tdata  = TDATA_W'({w_head.stream_id, w_head.pes_packet_length,
                                     w_head.pes_header_length, w_head.assembled_size,
                                     w_head.continuity, w_head.packet_pid,
                                     w_head.status, w_head.payload_byte});
    assign m_axis_tuser  = w_head.kind;
    assign m_axis_tlast  = w_head.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_pid <= {PID_W{1'b1}};
            r_byte_pos   <= '0;
            r_hdr_word   <= '0;
            r_adapt_len  <= '0;
            r_assembling <= 1'b0;
            r_last_cc    <= '0;
            r_pkt_acc    <= 1'b0;
            r_pkt_status <= ST_WRONG_PID;
            r_gathered   <= '0;
            r_pes_idx    <= '0;
            r_pes_sid    <= '0;
            r_pes_len    <= '0;
            r_pes_extra  <= '0;
            r_wr_ptr     <= '0;
            r_rd_ptr     <= '0;
            r_count      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_target_pid <= i_cfg_wdata;
            end
            r_byte_pos   <= n_byte_pos;
            r_hdr_word   <= n_hdr_word;
            r_adapt_len  <= n_adapt_len;
            r_assembling <= n_assembling;
            r_last_cc    <= n_last_cc;
            r_pkt_acc    <= n_pkt_acc;
            r_pkt_status <= n_pkt_status;
            r_gathered   <= n_gathered;
            r_pes_idx    <= n_pes_idx;
            r_pes_sid    <= n_pes_sid;
            r_pes_len    <= n_pes_len;
            r_pes_extra  <= n_pes_extra;
            r_wr_ptr     <= r_wr_ptr + AW'(w_npush);
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count      <= r_count + (AW+1)'(w_npush) - (AW+1)'(w_pop);
        end
    end

    // queue storage: payload result goes first when both are produced
    always_ff @(posedge i_clk) begin
        if (w_push_pay) begin
            r_mem[r_wr_ptr] <= w_res_pay;
        end
        if (w_push_status) begin
            r_mem[r_wr_ptr + AW'(w_push_pay)] <= w_res_status;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (AW+1)'(DEPTH))
        else $error("output queue overflow");

    a_status_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push_status |=> r_byte_pos == PW'(PACKET_BYTES))
        else $error("status report away from packet end");

    a_payload_after_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push_pay |-> (w_p >= PW'(4)))
        else $error("payload forwarded inside transport header");

    a_finished_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pkt_status == ST_FINISHED |-> !r_assembling)
        else $error("finished packet while still assembling");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count > (AW+1)'(DEPTH - 2)) |-> (w_npush == 2'd0))
        else $error("push into nearly full queue");

endmodule

>>> tb/sv/tb_ts_pes_assembler_core.sv
`timescale 1ns / 1ps

module tb_ts_pes_assembler_core;
    import ts_pes_pkg::*;

    localparam int PACKET_BYTES = 188;
    localparam int OFF_STATUS   = PAYLOAD_W;
    localparam int OFF_PID      = OFF_STATUS + 3;
    localparam int OFF_CC       = OFF_PID + PID_W;
    localparam int OFF_SIZE     = OFF_CC + CC_W;
    localparam int OFF_HLEN     = OFF_SIZE + SIZE_W;
    localparam int OFF_PLEN     = OFF_HLEN + HLEN_W;
    localparam int OFF_SID      = OFF_PLEN + PLEN_W;
    localparam logic [PID_W-1:0] PID_NULL = {PID_W{1'b1}};

    // Tracks the parser and PES state of the block and keeps the outputs it owes.
    class pes_stream_tracker;
        logic [PID_W-1:0]  target_pid;
        int                position;
        logic [31:0]       hdr;
        logic [7:0]        adapt_len;
        bit                assembling;
        logic [CC_W-1:0]   last_cc;
        bit                accepted;
        t_status           pkt_status;
        logic [SIZE_W-1:0] gathered;
        int                pes_idx;
        logic [SID_W-1:0]  sid;
        logic [PLEN_W-1:0] plen;
        logic [7:0]        extra;
        t_result           owed[$];
        int                errors;
        int                seen;

        function new();
            target_pid = PID_NULL;
            position   = 0;
            hdr        = '0;
            adapt_len  = '0;
            assembling = 0;
            last_cc    = '0;
            accepted   = 0;
            pkt_status = ST_WRONG_PID;
            gathered   = '0;
            pes_idx    = 0;
            sid        = '0;
            plen       = '0;
            extra      = '0;
            errors     = 0;
            seen       = 0;
        endfunction

        function logic [HLEN_W-1:0] header_length();
            case (sid)
                SID_PROGRAM_MAP, SID_PADDING, SID_PRIVATE_2, SID_ECM, SID_EMM,
                SID_DSMCC, SID_H222_E, SID_DIRECTORY: return HLEN_SHORT;
                default: return HLEN_LONG + HLEN_W'(extra);
            endcase
        endfunction

        function void push_output(t_kind k, logic [7:0] b, bit lst);
            t_result r;
            r.last              = lst;
            r.kind              = k;
            r.stream_id         = sid;
            r.pes_packet_length = plen;
            r.pes_header_length = header_length();
            r.assembled_size    = gathered;
            r.continuity        = hdr[CC_W-1:0];
            r.packet_pid        = hdr[8 +: PID_W];
            r.status            = pkt_status;
            r.payload_byte      = b;
            owed.push_back(r);
        endfunction

        function void decide_header();
            logic [PID_W-1:0] pid;
            logic [CC_W-1:0]  cc;
            logic [CC_W-1:0]  want_cc;
            pid     = hdr[8 +: PID_W];
            cc      = hdr[CC_W-1:0];
            want_cc = last_cc + 1'b1;
            accepted = 0;
            if (pid != target_pid) begin
                pkt_status = ST_WRONG_PID;
            end else if (hdr[22]) begin
                gathered   = '0;
                pes_idx    = 0;
                sid        = '0;
                plen       = '0;
                extra      = '0;
                assembling = 1;
                last_cc    = cc;
                accepted   = 1;
                pkt_status = ST_STARTED;
            end else if (!assembling) begin
                pkt_status = ST_NOT_STARTED;
            end else if (want_cc != cc) begin
                assembling = 0;
                gathered   = '0;
                pkt_status = ST_LOST;
            end else begin
                last_cc    = cc;
                accepted   = 1;
                pkt_status = ST_CONTINUE;
            end
        endfunction

        function void take_byte(logic [7:0] b, logic start);
            int p;
            bit payload;
            p = start ? 0 : position;
            payload = 0;
            // bytes past the packet end without a new start are dropped
            if (p >= PACKET_BYTES) return;
            position = p + 1;
            if (p == 0) begin
                hdr        = {24'h0, b};
                accepted   = 0;
                pkt_status = ST_WRONG_PID;
            end else if (p <= 3) begin
                hdr = {hdr[23:0], b};
                if (p == 3) decide_header();
            end else if (hdr[5]) begin
                if (p == 4) adapt_len = b;
                else if (p >= 5 + int'(adapt_len)) payload = 1;
            end else begin
                payload = 1;
            end

            if (payload && accepted) begin
                if (pkt_status == ST_STARTED && pes_idx < 9) begin
                    case (pes_idx)
                        3: sid = b;
                        4: plen[15:8] = b;
                        5: plen[7:0] = b;
                        8: extra = b;
                        default: ;
                    endcase
                    pes_idx++;
                end
                if (gathered != SIZE_MAX) gathered++;
                push_output(KIND_PAYLOAD, b, p != PACKET_BYTES - 1);
            end

            if (p == PACKET_BYTES - 1) begin
                if (accepted && pkt_status == ST_CONTINUE && plen != 0 &&
                    int'(gathered) >= int'(plen) + 6) begin
                    pkt_status = ST_FINISHED;
                    assembling = 0;
                end
                push_output(KIND_STATUS, 8'h00, 1);
            end
        endfunction

        task report(string what);
            errors++;
            if (errors <= 100) $display("mismatch at result %0d: %s", seen, what);
        endtask

        task check_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
        endtask

        task match_output(logic [TDATA_W-1:0] data, logic user, logic lst);
            t_result want;
            seen++;
            if (owed.size() == 0) begin
                report($sformatf("unexpected result, tdata %h", data));
                return;
            end
            want = owed.pop_front();
            check_field("kind", user, want.kind);
            check_field("payload_byte", data[0 +: PAYLOAD_W], want.payload_byte);
            check_field("status", data[OFF_STATUS +: 3], want.status);
            check_field("packet_pid", data[OFF_PID +: PID_W], want.packet_pid);
            check_field("continuity", data[OFF_CC +: CC_W], want.continuity);
            check_field("assembled_size", data[OFF_SIZE +: SIZE_W], want.assembled_size);
            check_field("pes_header_length", data[OFF_HLEN +: HLEN_W],
                        want.pes_header_length);
            check_field("pes_packet_length", data[OFF_PLEN +: PLEN_W],
                        want.pes_packet_length);
            check_field("stream_id", data[OFF_SID +: SID_W], want.stream_id);
            check_field("padding", 32'(data >> TDATA_BITS), 32'h0);
            check_field("last", lst, want.last);
        endtask
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [PID_W-1:0]   i_cfg_wdata = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata = '0;   // [7:0] stream_byte
    logic               s_axis_tuser = 1'b0; // [0] packet_start
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [TDATA_W-1:0] m_axis_tdata;        // payload_byte .. stream_id, zero padding
    logic               m_axis_tuser;        // [0] kind
    logic               m_axis_tlast;

    bit                 quiet = 0;
    logic [7:0]         pkt [PACKET_BYTES];
    pes_stream_tracker  tracker = new();

    ts_pes_assembler_core #(
        .PACKET_BYTES(PACKET_BYTES)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("tb_ts_pes_assembler_core failed");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                tracker.match_output(m_axis_tdata, m_axis_tuser, m_axis_tlast);
            if (s_axis_tvalid && s_axis_tready)
                tracker.take_byte(s_axis_tdata, s_axis_tuser);
            if (i_cfg_we)
                tracker.target_pid = i_cfg_wdata;
        end
    end

    always @(negedge i_clk) begin
        m_axis_tready <= quiet || ($urandom_range(99) >= 8);
    end

    // Entered and left at a falling edge; valid stays high for a following transfer.
    task automatic send_byte(logic [7:0] b, logic start);
        while (!quiet && $urandom_range(99) < 8) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= start;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (tracker.owed.size() != 0) @(negedge i_clk);
        // let bytes that owe nothing settle inside the block
        repeat (6) @(negedge i_clk);
    endtask

    task automatic write_target(logic [PID_W-1:0] pid);
        wait_drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= pid;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic send_packet(int nbytes, bit mark);
        for (int i = 0; i < nbytes; i++)
            send_byte(pkt[i], (i == 0) && mark);
    endtask

    // Fill pkt with a transport packet; a start packet carries a PES header at payload start.
    function automatic void build_packet(logic [PID_W-1:0] pid, bit pusi, logic [CC_W-1:0] cc,
                                         bit with_af, logic [7:0] af_len,
                                         logic [SID_W-1:0] sid, logic [PLEN_W-1:0] plen,
                                         logic [7:0] hlen_extra);
        int s;
        for (int i = 0; i < PACKET_BYTES; i++) pkt[i] = 8'($urandom);
        pkt[0] = ($urandom_range(9) == 0) ? 8'($urandom) : 8'h47;
        pkt[1] = {1'($urandom), pusi, 1'($urandom), pid[PID_W-1:8]};
        pkt[2] = pid[7:0];
        pkt[3] = {2'($urandom), with_af, 1'($urandom), cc};
        s = 4;
        if (with_af) begin
            pkt[4] = af_len;
            s = 5 + int'(af_len);
        end
        if (pusi) begin
            for (int k = 0; k < 9 && s + k < PACKET_BYTES; k++) begin
                case (k)
                    0, 1: pkt[s+k] = 8'h00;
                    2: pkt[s+k] = 8'h01;
                    3: pkt[s+k] = sid;
                    4: pkt[s+k] = plen[15:8];
                    5: pkt[s+k] = plen[7:0];
                    8: pkt[s+k] = hlen_extra;
                    default: ;
                endcase
            end
        end
    endfunction

    function automatic logic [SID_W-1:0] pick_sid();
        if ($urandom_range(1) == 0) return SID_W'($urandom);
        case ($urandom_range(7))
            0: return SID_PROGRAM_MAP;
            1: return SID_PADDING;
            2: return SID_PRIVATE_2;
            3: return SID_ECM;
            4: return SID_EMM;
            5: return SID_DSMCC;
            6: return SID_H222_E;
            default: return SID_DIRECTORY;
        endcase
    endfunction

    function automatic logic [PLEN_W-1:0] pick_plen();
        int r;
        r = $urandom_range(99);
        if (r < 15) return '0;
        if (r < 65) return PLEN_W'($urandom_range(1, 400));
        if (r < 80) return PLEN_W'($urandom_range(300, 700));
        if (r < 90) return {PLEN_W{1'b1}};
        return PLEN_W'($urandom);
    endfunction

    initial begin
        logic [PID_W-1:0] tgt;
        logic [PID_W-1:0] phase_pid [3];
        logic [CC_W-1:0]  next_cc;
        logic [CC_W-1:0]  cc;
        logic [7:0]       af_len;
        bit               with_af;
        int               fed;
        int               phase;
        int               pick;
        int               nbytes;
        int               tail;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // After reset the target is the null PID; the first packet comes unmarked.
        build_packet(PID_NULL, 1, 4'd0, 0, 8'd0, 8'hE0, 16'd20, 8'd5);
        send_packet(PACKET_BYTES, 0);
        // continuation reaches the PES length: finish
        build_packet(PID_NULL, 0, 4'd1, 1, 8'd0, 8'h00, 16'd0, 8'd0);
        send_packet(PACKET_BYTES, 1);
        // nothing assembling any more
        build_packet(PID_NULL, 0, 4'd2, 0, 8'd0, 8'h00, 16'd0, 8'd0);
        send_packet(PACKET_BYTES, 1);
        // start with only three payload bytes: PES fields stay clear
        build_packet(PID_NULL, 1, 4'd5, 1, 8'd180, 8'hC0, 16'h1234, 8'd0);
        send_packet(PACKET_BYTES, 1);
        // skipped counter value: lost
        build_packet(PID_NULL, 0, 4'd7, 0, 8'd0, 8'h00, 16'd0, 8'd0);
        send_packet(PACKET_BYTES, 1);

        write_target('0);
        build_packet('0, 1, 4'd15, 0, 8'd0, SID_PROGRAM_MAP, 16'd0, 8'hFF);
        send_packet(PACKET_BYTES, 1);
        // restart during assembly, adaptation length beyond the packet,
        // cut short by the next packet start; its header decision stays
        build_packet('0, 1, 4'd4, 1, 8'd255, 8'hBD, 16'd100, 8'hFF);
        send_packet(50, 1);
        // adaptation field fills the packet up to its end
        build_packet('0, 0, 4'd5, 1, 8'd183, 8'h00, 16'd0, 8'd0);
        send_packet(PACKET_BYTES, 1);
        // trailing bytes without a start are dropped
        for (int i = 0; i < 4; i++) send_byte(8'($urandom), 1'b0);

        phase_pid[0] = PID_W'($urandom_range(1, 8190));
        phase_pid[1] = PID_NULL;
        phase_pid[2] = '0;
        phase   = 0;
        tgt     = phase_pid[0];
        next_cc = '0;
        fed     = 0;
        write_target(tgt);

        while (fed < 540) begin
            if (phase < 2 && fed >= (phase + 1) * 180) begin
                phase++;
                tgt = phase_pid[phase];
                write_target(tgt);
                quiet = (phase == 1);
            end
            pick    = $urandom_range(99);
            with_af = $urandom_range(99) < 30;
            af_len  = ($urandom_range(9) == 0) ? 8'($urandom_range(150, 255))
                                               : 8'($urandom_range(0, 30));
            nbytes  = PACKET_BYTES;
            tail    = 0;
            if (pick < 15) begin
                cc = CC_W'($urandom);
                next_cc = cc + 1'b1;
                build_packet(tgt, 1, cc, with_af, af_len, pick_sid(), pick_plen(),
                             8'($urandom));
            end else if (pick < 62) begin
                build_packet(tgt, 0, next_cc, with_af, af_len, '0, '0, '0);
                next_cc = next_cc + 1'b1;
            end else if (pick < 72) begin
                build_packet(PID_W'($urandom), 1'($urandom), CC_W'($urandom), with_af,
                             af_len, pick_sid(), pick_plen(), 8'($urandom));
            end else if (pick < 78) begin
                cc = next_cc + CC_W'($urandom_range(1, 15));
                build_packet(tgt, 0, cc, with_af, af_len, '0, '0, '0);
            end else if (pick < 86) begin
                build_packet($urandom_range(1) ? tgt : PID_W'($urandom), 1'($urandom),
                             $urandom_range(1) ? next_cc : CC_W'($urandom), with_af,
                             af_len, pick_sid(), pick_plen(), 8'($urandom));
                nbytes = $urandom_range(1, PACKET_BYTES - 1);
            end else if (pick < 92) begin
                build_packet(tgt, 0, next_cc, with_af, af_len, '0, '0, '0);
                next_cc = next_cc + 1'b1;
                tail = $urandom_range(1, 6);
            end else begin
                nbytes = 0;
                for (int i = $urandom_range(1, 8); i > 0; i--) begin
                    send_byte(8'($urandom), $urandom_range(3) == 0);
                    fed++;
                end
            end
            send_packet(nbytes, 1);
            fed += nbytes;
            for (int i = 0; i < tail; i++) send_byte(8'($urandom), 1'b0);
        end

        wait_drain();
        repeat (10) @(negedge i_clk);
        if (tracker.errors == 0 && tracker.owed.size() == 0)
            $display("tb_ts_pes_assembler_core passed");
        else
            $display("tb_ts_pes_assembler_core failed");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/ts_pes_pkg.sv
hw/rtl/ts_pes_assembler_core.sv
tb/sv/tb_ts_pes_assembler_core.sv
